// File: src/rtc_pkg.sv
`default_nettype none

package rtc_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int POLY_STEPS = 5;
  localparam int LATENCY    = 41;

  localparam logic [2:0]  ADDR_REF_RESISTANCE = 3'd0;
  localparam logic [15:0] REF_RESET           = 16'd42850;

  localparam logic [30:0] BASE_P    = 31'd327680000;
  localparam logic [45:0] E_BASE    = 46'(64'd1527480889 * 64'd32768);
  localparam logic [14:0] E_SLOPE   = 15'd23100;
  localparam logic [31:0] A_SCALED  = 32'(64'd39083 * 64'd65536);
  localparam logic [29:0] RECIP25   = 30'd687194767;
  localparam logic [27:0] RECIP231  = 28'd148743456;
  localparam logic [21:0] T_HALF    = 22'd3784704;
  localparam logic [19:0] T_MAX_U   = 20'd100000;

  localparam logic signed [19:0] T_MIN = -20'sd25000;
  localparam logic signed [19:0] T_MAX = 20'sd100000;

  typedef logic [49:0] acc_t;

  localparam logic [63:0] POLY_Q40 [0:5] = '{
    64'd297,
    64'(-64'sd72837),
    64'(-64'sd203009),
    64'd2551123148,
    64'd2451831571628,
    64'(-64'sd266181710035577)
  };

  function automatic logic [6:0] frac_lut(input logic [4:0] b);
    logic [6:0] v;
    case (b)
      5'd0:  v = 7'd0;
      5'd1:  v = 7'd5;
      5'd2:  v = 7'd10;
      5'd3:  v = 7'd15;
      5'd4:  v = 7'd20;
      5'd5:  v = 7'd25;
      5'd6:  v = 7'd30;
      5'd7:  v = 7'd35;
      5'd8:  v = 7'd40;
      5'd9:  v = 7'd46;
      5'd10: v = 7'd51;
      5'd11: v = 7'd56;
      5'd12: v = 7'd61;
      5'd13: v = 7'd66;
      5'd14: v = 7'd71;
      5'd15: v = 7'd76;
      5'd16: v = 7'd81;
      5'd17: v = 7'd87;
      5'd18: v = 7'd92;
      5'd19: v = 7'd97;
      5'd20: v = 7'd102;
      5'd21: v = 7'd107;
      5'd22: v = 7'd112;
      5'd23: v = 7'd117;
      5'd24: v = 7'd122;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/rtc_sqrt.sv
`default_nettype none

module rtc_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] operand,
  output logic      [31:0] root
);

  logic [32:0] rem_q  [rtc_pkg::SQRT_STEPS];
  logic [31:0] root_q [rtc_pkg::SQRT_STEPS];
  logic [63:0] val_q  [rtc_pkg::SQRT_STEPS];

  logic [32:0] rem_i  [rtc_pkg::SQRT_STEPS];
  logic [31:0] root_i [rtc_pkg::SQRT_STEPS];
  logic [63:0] val_i  [rtc_pkg::SQRT_STEPS];

  for (genvar j = 0; j < rtc_pkg::SQRT_STEPS; j++) begin : g_step
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic [34:0] diff;

    if (j == 0) begin : g_first
      assign rem_i[j]  = '0;
      assign root_i[j] = '0;
      assign val_i[j]  = operand;
    end else begin : g_next
      assign rem_i[j]  = rem_q[j-1];
      assign root_i[j] = root_q[j-1];
      assign val_i[j]  = val_q[j-1];
    end

    assign rem_sh = {rem_i[j], val_i[j][63:62]};
    assign trial  = {1'b0, root_i[j], 2'b01};
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        val_q[j] <= {val_i[j][61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[j]  <= diff[32:0];
          root_q[j] <= {root_i[j][30:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh[32:0];
          root_q[j] <= {root_i[j][30:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[rtc_pkg::SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: src/rtc_poly.sv
`default_nettype none

module rtc_poly (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [30:0] r,
  output rtc_pkg::acc_t           acc
);

  rtc_pkg::acc_t mag_a [rtc_pkg::POLY_STEPS];
  logic          neg_a [rtc_pkg::POLY_STEPS];
  logic [30:0]   r_a   [rtc_pkg::POLY_STEPS];

  logic [48:0]   ph_b  [rtc_pkg::POLY_STEPS];
  logic [62:0]   pl_b  [rtc_pkg::POLY_STEPS];
  logic          neg_b [rtc_pkg::POLY_STEPS];
  logic [30:0]   r_b   [rtc_pkg::POLY_STEPS];

  rtc_pkg::acc_t acc_c [rtc_pkg::POLY_STEPS];
  logic [30:0]   r_c   [rtc_pkg::POLY_STEPS];

  rtc_pkg::acc_t acc_i [rtc_pkg::POLY_STEPS];
  logic [30:0]   r_i   [rtc_pkg::POLY_STEPS];

  for (genvar j = 0; j < rtc_pkg::POLY_STEPS; j++) begin : g_step
    logic [63:0] prod;
    logic [63:0] prod_signed;
    logic [63:0] sum;

    if (j == 0) begin : g_first
      assign acc_i[j] = rtc_pkg::POLY_Q40[0][49:0];
      assign r_i[j]   = r;
    end else begin : g_next
      assign acc_i[j] = acc_c[j-1];
      assign r_i[j]   = r_c[j-1];
    end

    assign prod        = {7'b0, ph_b[j], 8'b0} + {25'b0, pl_b[j][62:24]};
    assign prod_signed = neg_b[j] ? (64'd0 - prod) : prod;
    assign sum         = prod_signed + rtc_pkg::POLY_Q40[j+1];

    always_ff @(posedge clk) begin
      if (en) begin
        neg_a[j] <= acc_i[j][49];
        mag_a[j] <= acc_i[j][49] ? (50'd0 - acc_i[j]) : acc_i[j];
        r_a[j]   <= r_i[j];

        ph_b[j]  <= 49'(mag_a[j][49:32]) * 49'(r_a[j]);
        pl_b[j]  <= 63'(mag_a[j][31:0]) * 63'(r_a[j]);
        neg_b[j] <= neg_a[j];
        r_b[j]   <= r_a[j];

        acc_c[j] <= sum[49:0];
        r_c[j]   <= r_b[j];
      end
    end
  end

  assign acc = acc_c[rtc_pkg::POLY_STEPS-1];

endmodule

`default_nettype wire

// File: src/rtd_code_to_temperature.sv
`default_nettype none

// Converts a platinum RTD converter code into resistance and temperature.
// Input transfers on the s_axis channel carry the 15-bit ratio code and the
// converter's fault status byte; each one yields exactly one transfer on the
// m_axis channel carrying resistance in centiohms, temperature in signed
// hundredths of a degree (saturated to -250.00 .. 1000.00) and a fault flag.
// The reference resistor is set through the APB port at address 0 and should
// only be changed while no conversion is in flight.
// A new code is accepted in every cycle unless a result waits in the skid
// register. The pipeline wraps the 32-stage square root unit with the scaling,
// polynomial and division stages around it.
// When the receiver stalls, one result is held in a skid register and the
// whole pipeline freezes until it drains, so nothing is lost or repeated.
// Reset clears all valid bits and restores the reference resistor to 428.50
// ohm; the input is ready again as soon as reset is released.

module rtd_code_to_temperature (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [14:0] rtd_code, [22:15] status_byte, [23] zero
  input  wire logic [23:0] s_axis_tdata,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] resistance, [33:16] temperature, [34] sensor_fault, [39:35] zero
  output logic      [39:0] m_axis_tdata,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef struct packed {
    logic [15:0] res;
    logic        flt;
    logic        hi;
  } meta_t;

  logic [15:0] ref_resistance;

  logic        en;
  logic        skid_valid;
  logic [34:0] skid_data;
  logic [rtc_pkg::LATENCY-1:0] vld;

  logic [30:0] p1;
  logic        flt1;

  meta_t       meta2;
  logic [45:0] sub2;
  logic [58:0] pm2;
  logic [28:0] pl2;

  logic [63:0] v3;
  logic [24:0] a0_3;
  logic [28:0] pl3;

  logic [30:0] r4;
  rtc_pkg::acc_t acc19;
  logic [19:0] tlo20;

  logic [31:0] s35;
  logic [31:0] diff36;
  logic [26:0] n37;
  logic [54:0] pq38;
  logic [26:0] n38;
  logic [19:0] q39;
  logic [26:0] n39;
  logic [19:0] tup40;

  meta_t       meta_d [38];
  logic [19:0] tlo_d  [20];

  logic [15:0] res41;
  logic [17:0] temp41;
  logic        flt41;

  logic [30:0] y2;
  logic [45:0] e3;
  logic [28:0] rem4_full;
  logic [5:0]  rem4;
  logic [24:0] a4;
  logic [4:0]  b4;
  logic [31:0] r4_wide;
  logic [63:0] tlo_prod;
  logic [41:0] x37;
  logic [26:0] rem40;
  logic [19:0] q40;
  logic signed [19:0] t41;
  logic signed [19:0] t41_sat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rtc_pkg::ADDR_REF_RESISTANCE[2]) ?
                  {16'b0, ref_resistance} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_resistance <= rtc_pkg::REF_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rtc_pkg::ADDR_REF_RESISTANCE[2]) begin
      ref_resistance <= pwdata[15:0];
    end
  end

  assign en            = !skid_valid;
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[rtc_pkg::LATENCY-2:0], s_axis_tvalid};
    end
  end

  assign y2 = p1 - rtc_pkg::BASE_P;
  assign e3 = (sub2 > rtc_pkg::E_BASE) ? 46'd0 : (rtc_pkg::E_BASE - sub2);

  assign rem4_full = pl3 - 29'(a0_3) * 29'd25;
  assign rem4      = rem4_full[5:0];
  always_comb begin
    if (rem4 >= 6'd25) begin
      a4 = a0_3 + 25'd1;
      b4 = 5'(rem4 - 6'd25);
    end else begin
      a4 = a0_3;
      b4 = rem4[4:0];
    end
  end
  assign r4_wide = {a4, 7'b0} + {25'b0, rtc_pkg::frac_lut(b4)};

  assign tlo_prod = {{14{acc19[49]}}, acc19} * 64'd100 + 64'h0000_0080_0000_0000;

  assign x37   = 42'(diff36) * 42'd1000 + 42'(rtc_pkg::T_HALF);
  assign rem40 = n39 - 27'(q39) * 27'd231;
  assign q40   = (rem40 >= 27'd231) ? (q39 + 20'd1) : q39;

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= 31'(s_axis_tdata[14:0]) * 31'(ref_resistance);
      flt1 <= |s_axis_tdata[22:15];

      meta2 <= '{res: p1[30:15], flt: flt1, hi: (p1 >= rtc_pkg::BASE_P)};
      sub2  <= 46'(y2) * 46'(rtc_pkg::E_SLOPE);
      pm2   <= 59'(p1[28:0]) * 59'(rtc_pkg::RECIP25);
      pl2   <= p1[28:0];

      v3   <= {1'b0, e3, 17'b0};
      a0_3 <= pm2[58:34];
      pl3  <= pl2;

      r4 <= r4_wide[30:0];

      tlo20 <= tlo_prod[59:40];

      diff36 <= (s35 < rtc_pkg::A_SCALED) ? (rtc_pkg::A_SCALED - s35) : 32'd0;
      n37    <= x37[41:15];
      pq38   <= 55'(n37) * 55'(rtc_pkg::RECIP231);
      n38    <= n37;
      q39    <= pq38[54:35];
      n39    <= n38;
      tup40  <= (q40 > rtc_pkg::T_MAX_U) ? rtc_pkg::T_MAX_U : q40;

      meta_d[0] <= meta2;
      for (int i = 1; i < 38; i++) begin
        meta_d[i] <= meta_d[i-1];
      end
      tlo_d[0] <= tlo20;
      for (int i = 1; i < 20; i++) begin
        tlo_d[i] <= tlo_d[i-1];
      end

      res41  <= meta_d[37].res;
      temp41 <= t41_sat[17:0];
      flt41  <= meta_d[37].flt;
    end
  end

  assign t41 = meta_d[37].hi ? $signed(tup40) : $signed(tlo_d[19]);
  always_comb begin
    if (t41 < rtc_pkg::T_MIN) begin
      t41_sat = rtc_pkg::T_MIN;
    end else if (t41 > rtc_pkg::T_MAX) begin
      t41_sat = rtc_pkg::T_MAX;
    end else begin
      t41_sat = t41;
    end
  end

  rtc_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .operand (v3),
    .root    (s35)
  );

  rtc_poly u_poly (
    .clk (clk),
    .en  (en),
    .r   (r4),
    .acc (acc19)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[rtc_pkg::LATENCY-1] && !m_axis_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_data <= {flt41, temp41, res41};
    end
  end

  assign m_axis_tvalid = skid_valid || vld[rtc_pkg::LATENCY-1];
  assign m_axis_tdata  = skid_valid ? {5'b0, skid_data} : {5'b0, flt41, temp41, res41};

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [14:0] code;
    logic [7:0]  status;
  } reading_t;

  typedef struct packed {
    logic [15:0]        ohms;
    logic signed [17:0] temp;
    logic               fault;
  } conversion_t;

  typedef struct {
    logic [14:0]        code;
    logic [7:0]         status;
    bit                 known;
    logic signed [17:0] temp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rtd_code_to_temperature dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  logic [15:0]  rref;
  conversion_t  pending[$];
  int           mismatches = 0;
  int           received = 0;
  int           sent = 0;
  int           send_idle = 0;
  int           recv_idle = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, received);
    mismatches++;
  endtask

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_q24(input longint a, input logic [63:0] r);
    logic [63:0] m, p;
    m = (a < 0) ? -a : a;
    p = (((m >> 32) * r) << 8) + (((m & 64'hFFFF_FFFF) * r) >> 24);
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic conversion_t convert(input reading_t rd, input logic [15:0] rr);
    conversion_t c;
    logic [63:0] p, sub, e, s, diff, q, r;
    longint acc, v, t;
    longint coef[6];
    coef = '{64'sd297, -64'sd72837, -64'sd203009, 64'sd2551123148,
             64'sd2451831571628, -64'sd266181710035577};
    p = 64'(rd.code) * 64'(rr);
    if (p >= 64'd327680000) begin
      sub = 64'd23100 * (p - 64'd327680000);
      e = (sub > 64'd1527480889 * 64'd32768) ? 0 : 64'd1527480889 * 64'd32768 - sub;
      s = root64((e * 2) << 16);
      diff = (s < 64'd39083 * 64'd65536) ? 64'd39083 * 64'd65536 - s : 0;
      q = (diff * 1000 + 64'd3784704) / 64'd7569408;
      t = (q > 100000) ? 100000 : longint'(q);
    end else begin
      r = (p << 9) / 100;
      acc = coef[0];
      for (int i = 1; i < 6; i++) acc = scale_q24(acc, r) + coef[i];
      v = acc * 100 + (64'sd1 <<< 39);
      t = (v >= 0) ? (v >>> 40) : -((-v + (64'sd1 <<< 40) - 1) >>> 40);
    end
    if (t < -25000) t = -25000;
    if (t > 100000) t = 100000;
    c.ohms = p[30:15];
    c.temp = t[17:0];
    c.fault = (rd.status != 0);
    return c;
  endfunction

  task automatic apb_write(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= rtc_pkg::ADDR_REF_RESISTANCE;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    rref = value;
  endtask

  task automatic send(input reading_t rd, input bit known, input logic signed [17:0] temp);
    conversion_t c;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    c = convert(rd, rref);
    if (known && c.temp != temp) report("predictor temperature", c.temp, temp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, rd.status, rd.code};
    do @(posedge clk); while (!s_axis_tready);
    pending.push_back(c);
    sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        conversion_t got, want;
        got = {m_axis_tdata[15:0], m_axis_tdata[33:16], m_axis_tdata[34]};
        if (pending.size() == 0) begin
          report("unexpected transfer", m_axis_tdata, 0);
        end else begin
          want = pending.pop_front();
          if (got.ohms !== want.ohms) report("resistance", got.ohms, want.ohms);
          if (got.temp !== want.temp) report("temperature", got.temp, want.temp);
          if (got.fault !== want.fault) report("sensor_fault", got.fault, want.fault);
          if (m_axis_tdata[39:35] !== 0) report("padding", m_axis_tdata[39:35], 0);
        end
        received++;
      end
      m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (rtc_pkg::LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_burst(input int n);
    reading_t rd;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: rd.code = 15'($urandom_range(32767));
        1: rd.code = 15'($urandom_range(9000, 25000));
        2: rd.code = 15'($urandom_range(5000, 8000));
        default: rd.code = $urandom_range(1) ? 15'($urandom_range(20)) :
                                               15'(32767 - $urandom_range(20));
      endcase
      rd.status = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0;
      send(rd, 0, 0);
    end
  endtask

  row_t rows[$];
  logic [15:0] settings[4] = '{16'd42850, 16'd10000, 16'd65535, 16'd0};

  initial begin
    rref = rtc_pkg::REF_RESET;
    rows = '{
      '{15'd0,     8'h00, 1, -18'sd24209},
      '{15'd32767, 8'h00, 0, 0},
      '{15'd0,     8'hFF, 1, -18'sd24209},
      '{15'd7647,  8'h01, 0, 0},
      '{15'd7648,  8'h80, 0, 0},
      '{15'd16384, 8'h55, 0, 0},
      '{15'd5000,  8'hAA, 0, 0},
      '{15'd1,     8'h00, 0, 0},
      '{15'd20000, 8'h00, 0, 0},
      '{15'd10000, 8'h00, 0, 0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send('{rows[i].code, rows[i].status}, rows[i].known, rows[i].temp);
    end
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(ph == 3 ? 16'($urandom_range(10000, 65535)) : settings[ph]);
      send('{15'd32767, 8'h00}, 0, 0);
      send('{15'd0, 8'h01}, 1, -18'sd24209);
      for (int mode = 0; mode < 3; mode++) begin
        send_idle = (mode == 0) ? 28 : (mode == 1) ? 87 : 0;
        recv_idle = (mode == 0) ? 87 : (mode == 1) ? 28 : 0;
        random_burst(160);
      end
      send_idle = 0;
      recv_idle = 0;
      drain();
    end
    $display("Sent %0d readings and checked %0d conversions at the reset reference",
             sent, received);
    $display("and four written ones, with idle patterns on both sides.");
    if (mismatches == 0 && pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
